// File: rtl/stip_pkg.sv
// Shared types, codes and character constants of the string to integer parser.
`default_nettype none

package stip_pkg;

  // Default saturation limit of the character position counter
  localparam int unsigned DEFAULT_MAX_LENGTH = 65535;

  // Field widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned BASE_W   = 6;
  localparam int unsigned CFG_AW   = 1;
  localparam int unsigned CFG_DW   = 6;
  localparam int unsigned OUT_DW   = 88;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_NUMBER_BASE = 1'b0;
  localparam logic [CFG_AW-1:0] REG_SIGNED_MODE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // Bases and limits
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

  localparam logic [VALUE_W-1:0] SIGNED_MIN = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] SIGNED_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [VALUE_W-1:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
  localparam logic [CHAR_W-1:0] DIGIT_TEN  = 8'd10;
  localparam logic [CHAR_W-1:0] DIGIT_NONE = 8'hff;

  // Parse phase
  typedef enum logic [1:0] {
    PH_WS     = 2'd0,
    PH_START  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Pending lookahead after a leading zero or a minus sign
  typedef enum logic [1:0] {
    LA_NONE   = 2'd0,
    LA_ZERO   = 2'd1,
    LA_ZERO_X = 2'd2,
    LA_MINUS  = 2'd3
  } look_t;

  // Parse state captured on the last character of a string
  typedef struct packed {
    logic [VALUE_W-1:0]  acc;
    logic                overflow;
    logic                neg_unsigned;
    logic                neg_signed;
    logic                digit_seen;
    logic                signed_mode;
    logic [OFFSET_W-1:0] stop_offset;
  } snap_t;

  // Value of one character as a digit; large for anything that is no digit
  function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    if (c >= CH_LA) begin
      d = c - CH_LA + DIGIT_TEN;
    end else if (c >= CH_UA) begin
      d = c - CH_UA + DIGIT_TEN;
    end else if (c <= CH_9) begin
      d = c - CH_0;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/stip_scan.sv
// Per-character parse state: whitespace, sign, radix prefix and digit accumulation.
`default_nettype none

module stip_scan #(
  parameter int unsigned MAX_LENGTH = stip_pkg::DEFAULT_MAX_LENGTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step_en,
  input  wire logic [stip_pkg::CHAR_W-1:0]  char_code,
  input  wire logic                         is_last,
  input  wire logic [stip_pkg::BASE_W-1:0]  number_base,
  input  wire logic                         signed_mode,
  output stip_pkg::snap_t                   snap
);

  localparam int unsigned POS_W = $clog2(MAX_LENGTH + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

  stip_pkg::phase_t                  phase_r, phase_nxt, phase_post;
  stip_pkg::look_t                   la_r, la_nxt, la_post;
  logic [stip_pkg::VALUE_W-1:0]      acc_r, acc_nxt, acc_post;
  logic                              ovf_r, ovf_nxt, ovf_post;
  logic                              negu_r, negu_nxt, negu_post;
  logic                              negs_r, negs_nxt, negs_post;
  logic                              digit_r, digit_nxt, digit_post;
  logic [stip_pkg::BASE_W-1:0]       abase_r, abase_nxt, abase_post;
  logic [POS_W-1:0]                  pos_r, pos_nxt;
  logic [POS_W-1:0]                  stop_r, stop_nxt, stop_post;

  logic [POS_W:0]                    pos_sum;
  logic [POS_W-1:0]                  pos_inc;
  logic [stip_pkg::CHAR_W-1:0]       dval;
  logic [stip_pkg::BASE_W-1:0]       try_base;
  logic                              do_try;
  logic                              do_body;
  logic [stip_pkg::VALUE_W+5:0]      mac;
  logic                              is_ws;
  logic                              is_alnum;
  logic                              is_hex;
  logic                              base_bad;
  logic                              base_pfx;

  // Saturating position of the next character
  assign pos_sum = {1'b0, pos_r} + (POS_W + 1)'(1);
  assign pos_inc = (pos_r >= POS_MAX) ? POS_MAX : pos_sum[POS_W-1:0];

  // Character classes
  assign dval     = stip_pkg::digit_value(char_code);
  assign is_ws    = (char_code == stip_pkg::CH_SPACE) ||
                    ((char_code >= stip_pkg::CH_TAB) && (char_code <= stip_pkg::CH_CR));
  assign is_alnum = ((char_code >= stip_pkg::CH_0) && (char_code <= stip_pkg::CH_9)) ||
                    ((char_code >= stip_pkg::CH_UA) && (char_code <= stip_pkg::CH_UZ)) ||
                    ((char_code >= stip_pkg::CH_LA) && (char_code <= stip_pkg::CH_LZ));
  assign is_hex   = ((char_code >= stip_pkg::CH_0) && (char_code <= stip_pkg::CH_9)) ||
                    ((char_code >= stip_pkg::CH_UA) && (char_code <= stip_pkg::CH_UF)) ||
                    ((char_code >= stip_pkg::CH_LA) && (char_code <= stip_pkg::CH_LF));
  assign base_bad = (number_base == stip_pkg::BASE_ONE) || (number_base > stip_pkg::BASE_MAX);
  assign base_pfx = ((number_base == stip_pkg::BASE_AUTO) ||
                     (number_base == stip_pkg::BASE_HEX)) && (char_code == stip_pkg::CH_0);

  // One multiply-add by the radix; any carry past 64 bits is an overflow
  assign mac = (stip_pkg::VALUE_W + 6)'(acc_r) * (stip_pkg::VALUE_W + 6)'(try_base) +
               (stip_pkg::VALUE_W + 6)'(dval[stip_pkg::BASE_W-1:0]);

  // Decode one character into the state after it
  always_comb begin
    phase_post = phase_r;
    la_post    = la_r;
    acc_post   = acc_r;
    ovf_post   = ovf_r;
    negu_post  = negu_r;
    negs_post  = negs_r;
    digit_post = digit_r;
    abase_post = abase_r;
    stop_post  = stop_r;
    do_try     = 1'b0;
    do_body    = 1'b0;
    try_base   = abase_r;

    if (phase_r != stip_pkg::PH_DONE) begin
      if (char_code == stip_pkg::CH_NUL) begin
        phase_post = stip_pkg::PH_DONE;
        la_post    = stip_pkg::LA_NONE;
      end else begin
        case (phase_r)
          stip_pkg::PH_WS: begin
            if (is_ws) begin
              phase_post = stip_pkg::PH_WS;
            end else if (char_code == stip_pkg::CH_MINUS) begin
              negu_post  = 1'b1;
              la_post    = stip_pkg::LA_MINUS;
              phase_post = stip_pkg::PH_START;
            end else if (char_code == stip_pkg::CH_PLUS) begin
              phase_post = stip_pkg::PH_START;
            end else begin
              do_body = 1'b1;
            end
          end
          stip_pkg::PH_START: begin
            // a minus counts for signed mode only before an alphanumeric
            if ((la_r == stip_pkg::LA_MINUS) && is_alnum) begin
              negs_post = 1'b1;
            end
            la_post = stip_pkg::LA_NONE;
            do_body = 1'b1;
          end
          stip_pkg::PH_DIGITS: begin
            if ((la_r == stip_pkg::LA_ZERO) &&
                ((char_code == stip_pkg::CH_LX) || (char_code == stip_pkg::CH_UX))) begin
              la_post = stip_pkg::LA_ZERO_X;
            end else if (la_r == stip_pkg::LA_ZERO_X) begin
              la_post = stip_pkg::LA_NONE;
              if (is_hex) begin
                try_base = stip_pkg::BASE_HEX;
                do_try   = 1'b1;
              end else begin
                phase_post = stip_pkg::PH_DONE;
              end
            end else begin
              la_post = stip_pkg::LA_NONE;
              do_try  = 1'b1;
            end
          end
          default: begin
            phase_post = phase_r;
          end
        endcase

        // First character of the number body: resolve the radix
        if (do_body) begin
          if (base_bad) begin
            phase_post = stip_pkg::PH_DONE;
          end else if (base_pfx) begin
            try_base = (number_base == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_OCT
                                                            : stip_pkg::BASE_HEX;
            la_post  = stip_pkg::LA_ZERO;
            do_try   = 1'b1;
          end else begin
            try_base = (number_base == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC
                                                            : number_base;
            do_try   = 1'b1;
          end
        end

        // Take the digit or stop at it
        if (do_try) begin
          abase_post = try_base;
          if (dval >= stip_pkg::CHAR_W'(try_base)) begin
            phase_post = stip_pkg::PH_DONE;
          end else begin
            acc_post   = mac[stip_pkg::VALUE_W-1:0];
            ovf_post   = ovf_r | (|mac[stip_pkg::VALUE_W+5:stip_pkg::VALUE_W]);
            digit_post = 1'b1;
            stop_post  = pos_inc;
            phase_post = stip_pkg::PH_DIGITS;
          end
        end
      end
    end
  end

  // Hand the finished parse to the result stage
  always_comb begin
    snap.acc          = acc_post;
    snap.overflow     = ovf_post;
    snap.neg_unsigned = negu_post;
    snap.neg_signed   = negs_post;
    snap.digit_seen   = digit_post;
    snap.signed_mode  = signed_mode;
    snap.stop_offset  = stip_pkg::OFFSET_W'(stop_post);
  end

  // Advance on each transaction; start over after the last character
  always_comb begin
    phase_nxt = phase_r;
    la_nxt    = la_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    negu_nxt  = negu_r;
    negs_nxt  = negs_r;
    digit_nxt = digit_r;
    abase_nxt = abase_r;
    pos_nxt   = pos_r;
    stop_nxt  = stop_r;
    if (step_en) begin
      if (is_last) begin
        phase_nxt = stip_pkg::PH_WS;
        la_nxt    = stip_pkg::LA_NONE;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        negu_nxt  = 1'b0;
        negs_nxt  = 1'b0;
        digit_nxt = 1'b0;
        abase_nxt = '0;
        pos_nxt   = '0;
        stop_nxt  = '0;
      end else begin
        phase_nxt = phase_post;
        la_nxt    = la_post;
        acc_nxt   = acc_post;
        ovf_nxt   = ovf_post;
        negu_nxt  = negu_post;
        negs_nxt  = negs_post;
        digit_nxt = digit_post;
        abase_nxt = abase_post;
        pos_nxt   = pos_inc;
        stop_nxt  = stop_post;
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= stip_pkg::PH_WS;
      la_r    <= stip_pkg::LA_NONE;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      negu_r  <= 1'b0;
      negs_r  <= 1'b0;
      digit_r <= 1'b0;
      abase_r <= '0;
      pos_r   <= '0;
      stop_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      la_r    <= la_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      negu_r  <= negu_nxt;
      negs_r  <= negs_nxt;
      digit_r <= digit_nxt;
      abase_r <= abase_nxt;
      pos_r   <= pos_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/string_to_integer_parser_unit.sv
// Top level of the string to integer parser: config registers, result stage, output register.
// Throughput: one character per cycle while in_tready is high; each accepted character updates the parse state.
// After the transaction that carries in_tlast, the capture stage takes the finished parse
//   and the output register then takes it saturated or negated.
// in_tready drops only while both the capture stage and the output register hold results.
// Reset (rst_n low, synchronous): parse state cleared, no result pending, number_base 10,
//   signed_mode 0.
`default_nettype none

module string_to_integer_parser_unit #(
  parameter int unsigned MAX_LENGTH = stip_pkg::DEFAULT_MAX_LENGTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [stip_pkg::CHAR_W-1:0]  in_tdata,   // [7:0] char_code
  input  wire logic                         in_tlast,   // is_last
  // result channel
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [stip_pkg::OUT_DW-1:0]       out_tdata,  // [63:0] value, [65:64] status,
                                                        // [81:66] end_offset, rest zero
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [stip_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [stip_pkg::CFG_DW-1:0]  cfg_wdata
);

  logic [stip_pkg::BASE_W-1:0]    base_r;
  logic                           smode_r;
  logic                           in_acc;
  stip_pkg::snap_t                snap;
  stip_pkg::snap_t                fin_r;
  logic                           fin_v_r, fin_v_nxt;
  logic                           out_v_r, out_v_nxt;
  logic                           out_load;
  logic [stip_pkg::VALUE_W-1:0]   mag;
  logic [stip_pkg::VALUE_W-1:0]   mag_neg;
  logic [stip_pkg::VALUE_W-1:0]   res_value;
  logic [stip_pkg::STATUS_W-1:0]  res_status;
  logic [stip_pkg::OFFSET_W-1:0]  res_offset;
  logic [stip_pkg::VALUE_W-1:0]   value_r;
  logic [stip_pkg::STATUS_W-1:0]  status_r;
  logic [stip_pkg::OFFSET_W-1:0]  offset_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= stip_pkg::BASE_RESET;
      smode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        stip_pkg::REG_NUMBER_BASE: base_r  <= cfg_wdata[stip_pkg::BASE_W-1:0];
        stip_pkg::REG_SIGNED_MODE: smode_r <= cfg_wdata[0];
        default: base_r <= base_r;
      endcase
    end
  end

  // Handshake: move the capture stage whenever the output register frees up
  assign out_load  = fin_v_r && (!out_v_r || out_tready);
  assign in_tready = !fin_v_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  stip_scan #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_acc),
    .char_code   (in_tdata),
    .is_last     (in_tlast),
    .number_base (base_r),
    .signed_mode (smode_r),
    .snap        (snap)
  );

  // Capture stage for a finished parse
  always_comb begin
    fin_v_nxt = fin_v_r;
    if (out_load) begin
      fin_v_nxt = 1'b0;
    end
    if (in_acc && in_tlast) begin
      fin_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else begin
      fin_v_r <= fin_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      fin_r <= snap;
    end
  end

  // Saturate, negate and classify the captured parse
  assign mag     = (fin_r.signed_mode && fin_r.overflow) ? stip_pkg::ALL_ONES : fin_r.acc;
  assign mag_neg = '0 - mag;

  always_comb begin
    res_value  = '0;
    res_status = stip_pkg::STATUS_OK;
    res_offset = fin_r.stop_offset;
    if (!fin_r.digit_seen) begin
      res_status = stip_pkg::STATUS_BAD;
      res_offset = '0;
    end else if (fin_r.signed_mode) begin
      if (mag[stip_pkg::VALUE_W-1]) begin
        if ((mag == stip_pkg::SIGNED_MIN) && fin_r.neg_signed) begin
          res_value = mag;
        end else begin
          res_value  = fin_r.neg_signed ? stip_pkg::SIGNED_MIN : stip_pkg::SIGNED_MAX;
          res_status = stip_pkg::STATUS_RANGE;
        end
      end else begin
        res_value = fin_r.neg_signed ? mag_neg : mag;
      end
    end else if (fin_r.overflow) begin
      res_value  = stip_pkg::ALL_ONES;
      res_status = stip_pkg::STATUS_RANGE;
    end else begin
      res_value = fin_r.neg_unsigned ? mag_neg : mag;
    end
  end

  // Output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (out_load) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value_r  <= res_value;
      status_r <= res_status;
      offset_r <= res_offset;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(stip_pkg::OUT_DW - stip_pkg::VALUE_W - stip_pkg::STATUS_W -
                         stip_pkg::OFFSET_W){1'b0}}, offset_r, status_r, value_r};

  // A last transaction always leaves a captured parse behind
  a_last_captured: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> fin_v_r)
    else $error("last transaction not captured");

  // A captured parse is never dropped while the output is blocked
  a_fin_held: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r && !out_load |=> fin_v_r)
    else $error("captured parse lost");

  // Input stalls only when both result stages are full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> fin_v_r && out_v_r && !out_tready)
    else $error("input stalled without cause");

  // A failed conversion reports zero value and zero offset
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (status_r == stip_pkg::STATUS_BAD) |-> (value_r == '0) && (offset_r == '0))
    else $error("failed conversion with nonzero fields");

  // The status code never takes the unused encoding
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (status_r == stip_pkg::STATUS_OK) || (status_r == stip_pkg::STATUS_BAD) ||
                (status_r == stip_pkg::STATUS_RANGE))
    else $error("bad status code");

endmodule

`default_nettype wire
